// File: rtl/core/planar_to_pen_index_converter_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef PLANAR_TO_PEN_INDEX_CONVERTER_ASSERT_SVH
`define PLANAR_TO_PEN_INDEX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPIC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppic port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPIC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ppic port check failed");

`endif

// File: rtl/core/ppic_pkg.sv
// Types, constants and pen tables of the planar-to-pen index converter.
`default_nettype none

package ppic_pkg;

  localparam int PIXELS_PER_WORD = 16;
  localparam int MAX_PLANES      = 8;
  localparam int NUM_PLANES      = 8;
  localparam int WORD_W          = 16;
  localparam int PIX_W           = $clog2(PIXELS_PER_WORD);
  localparam int IDX_W           = 8;
  localparam int COLOURS         = 256;
  localparam int EPOCH_W         = 8;
  localparam int PLANE_COUNT_W   = 4;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [EPOCH_W-1:0]       epoch_t;
  typedef logic [PLANE_COUNT_W-1:0] plane_count_t;

  localparam idx_t         IDX_MAX         = '1;
  localparam epoch_t       EPOCH_MAX       = '1;
  localparam epoch_t       EPOCH_FIRST     = epoch_t'(1);
  localparam plane_count_t PLANE_COUNT_RST = plane_count_t'(1);

  typedef enum logic [1:0] {
    DEPTH_1,
    DEPTH_2,
    DEPTH_4,
    DEPTH_8
  } depth_e;

  // One pixel issued by the sequencer towards the colour map
  typedef struct packed {
    logic   vld;
    idx_t   idx;
    idx_t   pen;
    logic   err;
    logic   last;
    epoch_t epoch;
  } pix_req_t;

  // One finished pixel result
  typedef struct packed {
    logic vld;
    idx_t idx;
    idx_t pen;
    logic first;
    logic err;
    logic last;
  } pix_res_t;

  // Colour map status towards the sequencer
  typedef struct packed {
    logic clearing;
    logic s1_busy;
    logic clr_done;
  } seen_stat_t;

  localparam idx_t PEN_BASE16 [16] = '{
    8'd0, 8'd2, 8'd3, 8'd6, 8'd4, 8'd7, 8'd5, 8'd8,
    8'd9, 8'd10, 8'd11, 8'd14, 8'd12, 8'd15, 8'd13, 8'd1
  };

  localparam idx_t PEN_BASE4 [4] = '{8'd0, 8'd2, 8'd3, 8'd1};

  function automatic logic depth_ok(plane_count_t pc);
    return (pc inside {4'd1, 4'd2, 4'd4, 4'd8}) && (int'(pc) <= MAX_PLANES);
  endfunction

  function automatic depth_e depth_code(plane_count_t pc);
    depth_e d;
    case (pc)
      4'd2:    d = DEPTH_2;
      4'd4:    d = DEPTH_4;
      4'd8:    d = DEPTH_8;
      default: d = DEPTH_1;
    endcase
    return d;
  endfunction

  function automatic logic [NUM_PLANES-1:0] plane_mask(depth_e d);
    logic [NUM_PLANES-1:0] m;
    case (d)
      DEPTH_1: m = 8'h01;
      DEPTH_2: m = 8'h03;
      DEPTH_4: m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic idx_t pen_of(depth_e d, idx_t idx);
    idx_t pen;
    case (d)
      DEPTH_1: pen = {7'd0, idx[0]};
      DEPTH_2: pen = PEN_BASE4[idx[1:0]];
      DEPTH_4: pen = PEN_BASE16[idx[3:0]];
      default: begin
        if (idx < 8'd15) begin
          pen = PEN_BASE16[idx[3:0]];
        end else if (idx == 8'd15) begin
          pen = 8'd255;
        end else if (idx == IDX_MAX) begin
          pen = 8'd1;
        end else begin
          pen = idx;
        end
      end
    endcase
    return pen;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ppic_seq.sv
// Word register and pixel sequencer: takes a plane word, one pixel per cycle on adv_i.
`default_nettype none

module ppic_seq (
  input  wire                                                  clk_i,
  input  wire                                                  rst_ni,
  input  wire                                                  in_valid_i,
  output logic                                                 in_stall_o,
  input  wire [ppic_pkg::NUM_PLANES-1:0][ppic_pkg::WORD_W-1:0] planes_i,
  input  wire                                                  row_begin_i,
  input  ppic_pkg::plane_count_t                               plane_count_i,
  input  wire                                                  adv_i,
  input  ppic_pkg::seen_stat_t                                 stat_i,
  output logic                                                 clr_start_o,
  output ppic_pkg::pix_req_t                                   req_o
);

  logic [ppic_pkg::NUM_PLANES-1:0][ppic_pkg::WORD_W-1:0] words_q;
  logic                                                  s0_vld_q;
  logic [ppic_pkg::PIX_W-1:0]                            cnt_q;
  logic                                                  err_q;
  ppic_pkg::depth_e                                      dep_q;
  ppic_pkg::epoch_t                                      epoch_q;

  logic                            last_beat;
  logic                            s0_free;
  logic                            wrap_hold;
  logic                            accept;
  logic [ppic_pkg::NUM_PLANES-1:0] mask;
  ppic_pkg::idx_t                  asm_idx;

  // Handshake: take a word once the current one issues its final pixel
  always_comb begin
    last_beat   = err_q || (cnt_q == ppic_pkg::PIX_W'(ppic_pkg::PIXELS_PER_WORD - 1));
    s0_free     = !s0_vld_q || (adv_i && last_beat);
    wrap_hold   = row_begin_i && (epoch_q == ppic_pkg::EPOCH_MAX);
    in_stall_o  = stat_i.clearing || !s0_free || wrap_hold;
    accept      = in_valid_i && !in_stall_o;
    clr_start_o = in_valid_i && wrap_hold && !s0_vld_q && !stat_i.s1_busy
                  && !stat_i.clearing;
  end

  // Assemble the colour index from one bit of each used plane
  always_comb begin
    mask = ppic_pkg::plane_mask(dep_q);
    for (int p = 0; p < ppic_pkg::NUM_PLANES; p++) begin
      asm_idx[p] = words_q[p][cnt_q] & mask[p];
    end
    req_o.vld   = s0_vld_q;
    req_o.idx   = err_q ? '0 : asm_idx;
    req_o.pen   = err_q ? '0 : ppic_pkg::pen_of(dep_q, asm_idx);
    req_o.err   = err_q;
    req_o.last  = last_beat;
    req_o.epoch = epoch_q;
  end

  // Hold the plane words for the length of the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      words_q <= planes_i;
    end
  end

  // Advance the pixel counter, bump the row epoch on a row start, reset it after clearing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      dep_q    <= ppic_pkg::DEPTH_1;
      epoch_q  <= ppic_pkg::EPOCH_FIRST;
    end else begin
      if (stat_i.clr_done) begin
        epoch_q <= ppic_pkg::EPOCH_FIRST;
      end
      if (accept) begin
        s0_vld_q <= 1'b1;
        cnt_q    <= '0;
        err_q    <= !ppic_pkg::depth_ok(plane_count_i);
        dep_q    <= ppic_pkg::depth_code(plane_count_i);
        if (row_begin_i) begin
          epoch_q <= epoch_q + 1'b1;
        end
      end else if (adv_i && s0_vld_q) begin
        if (last_beat) begin
          s0_vld_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ppic_seen.sv
// Used-colour map: epoch-tagged memory with read-modify-write, forwarding and clearing pass.
`default_nettype none

module ppic_seen (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  adv_i,
  input  ppic_pkg::pix_req_t   req_i,
  input  wire                  clr_start_i,
  output ppic_pkg::seen_stat_t stat_o,
  output ppic_pkg::pix_res_t   res_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } seen_state_e;

  ppic_pkg::epoch_t   tag_mem [ppic_pkg::COLOURS];

  seen_state_e        state_q;
  ppic_pkg::idx_t     ptr_q;
  ppic_pkg::pix_req_t s1_q;
  ppic_pkg::epoch_t   rd_q;
  logic               lw_vld_q;
  ppic_pkg::idx_t     lw_idx_q;
  ppic_pkg::epoch_t   lw_epoch_q;

  logic clearing;
  logic wr_en;
  logic fwd_hit;
  logic seen;

  always_comb begin
    clearing = (state_q == ST_CLEAR);
    wr_en    = adv_i && s1_q.vld && !s1_q.err;
  end

  // Tag memory: clearing pass or write-back of the current epoch; registered read
  always_ff @(posedge clk_i) begin
    if (clearing) begin
      tag_mem[ptr_q] <= '0;
    end else if (wr_en) begin
      tag_mem[s1_q.idx] <= s1_q.epoch;
    end
    if (adv_i) begin
      rd_q <= tag_mem[req_i.idx];
    end
  end

  // Sweep the memory after reset and on epoch wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ptr_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == ppic_pkg::IDX_MAX) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (clr_start_i) begin
            state_q <= ST_CLEAR;
            ptr_q   <= '0;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
          ptr_q   <= '0;
        end
      endcase
    end
  end

  // Advance the lookup stage and remember the last write for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      lw_vld_q   <= 1'b0;
      lw_idx_q   <= '0;
      lw_epoch_q <= '0;
    end else begin
      if (adv_i) begin
        s1_q <= req_i;
      end
      if (clearing) begin
        lw_vld_q <= 1'b0;
      end else if (wr_en) begin
        lw_vld_q   <= 1'b1;
        lw_idx_q   <= s1_q.idx;
        lw_epoch_q <= s1_q.epoch;
      end
    end
  end

  // Colour was seen in this row if its tag matches or the previous pixel just wrote it
  always_comb begin
    fwd_hit     = lw_vld_q && (lw_idx_q == s1_q.idx) && (lw_epoch_q == s1_q.epoch);
    seen        = (rd_q == s1_q.epoch) || fwd_hit;
    res_o.vld   = s1_q.vld;
    res_o.idx   = s1_q.idx;
    res_o.pen   = s1_q.pen;
    res_o.first = !s1_q.err && !seen;
    res_o.err   = s1_q.err;
    res_o.last  = s1_q.last;

    stat_o.clearing = clearing;
    stat_o.s1_busy  = s1_q.vld;
    stat_o.clr_done = clearing && (ptr_q == ppic_pkg::IDX_MAX);
  end

endmodule

`default_nettype wire

// File: rtl/core/planar_to_pen_index_converter.sv
// Top level of the planar-to-pen index converter with configuration and output registers.
//
// A word of up to eight 16-bit bitplanes is turned into 16 pixel results, one per cycle
// while the output is not stalled, from bit 0 to bit 15; the next word is taken in the
// cycle its predecessor issues its last pixel. A word seen with an invalid plane count gives
// a single error result. The first result passes the colour-map read and the output
// register after acceptance. The used-colour map is an epoch-tagged 256-entry memory
// read and written back once per pixel; after reset, and before the row start at which
// the 8-bit epoch tag runs out (the 255th row start, then every 254th), a clearing pass
// over all 256 entries runs and no word is taken meanwhile; that row start also waits for
// the pixels in flight to drain. Configuration writes are always ready.
`default_nettype none

module planar_to_pen_index_converter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [ppic_pkg::PLANE_COUNT_W-1:0] cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_0_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_1_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_2_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_3_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_4_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_5_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_6_i,
  input  wire [ppic_pkg::WORD_W-1:0]   plane_word_7_i,
  input  wire                          row_begin_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [ppic_pkg::IDX_W-1:0]   device_index_o,
  output logic [ppic_pkg::IDX_W-1:0]   pen_number_o,
  output logic                         first_use_o,
  output logic                         depth_error_o,
  output logic                         last_pixel_o
);

  logic [ppic_pkg::NUM_PLANES-1:0][ppic_pkg::WORD_W-1:0] planes;
  ppic_pkg::plane_count_t plane_count_q;
  ppic_pkg::pix_req_t     req;
  ppic_pkg::pix_res_t     res;
  ppic_pkg::seen_stat_t   stat;
  logic                   clr_start;
  logic                   adv;
  logic                   out_vld_q;

  assign planes = {plane_word_7_i, plane_word_6_i, plane_word_5_i, plane_word_4_i,
                   plane_word_3_i, plane_word_2_i, plane_word_1_i, plane_word_0_i};

  // Pipeline moves whenever the output register is free or being emptied
  assign adv         = !out_vld_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;

  // Plane count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= ppic_pkg::PLANE_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      plane_count_q <= cfg_data_i;
    end
  end

  ppic_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .planes_i      (planes),
    .row_begin_i   (row_begin_i),
    .plane_count_i (plane_count_q),
    .adv_i         (adv),
    .stat_i        (stat),
    .clr_start_o   (clr_start),
    .req_o         (req)
  );

  ppic_seen u_seen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_i       (req),
    .clr_start_i (clr_start),
    .stat_o      (stat),
    .res_o       (res)
  );

  // Output transaction valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res.vld;
    end
  end

  // Output payload: load on advance, hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv && res.vld) begin
      device_index_o <= res.idx;
      pen_number_o   <= res.pen;
      first_use_o    <= res.first;
      depth_error_o  <= res.err;
      last_pixel_o   <= res.last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ppic_checker.sv
// Port-level checker for the planar-to-pen index converter, bound to the top level.
`default_nettype none

`include "planar_to_pen_index_converter_assert.svh"

module ppic_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               cfg_valid_i,
  input wire                               cfg_ready_o,
  input wire [ppic_pkg::PLANE_COUNT_W-1:0] cfg_data_i,
  input wire                               in_valid_i,
  input wire                               in_stall_o,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_0_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_1_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_2_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_3_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_4_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_5_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_6_i,
  input wire [ppic_pkg::WORD_W-1:0]        plane_word_7_i,
  input wire                               row_begin_i,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire [ppic_pkg::IDX_W-1:0]         device_index_o,
  input wire [ppic_pkg::IDX_W-1:0]         pen_number_o,
  input wire                               first_use_o,
  input wire                               depth_error_o,
  input wire                               last_pixel_o
);

  // Hold a stalled result transaction
  `PPIC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(device_index_o) && $stable(pen_number_o) && $stable(last_pixel_o))

  // Error result is a lone, cleared transaction
  `PPIC_ASSERT_IMP(a_err_shape, clk_i, rst_ni, out_valid_o && depth_error_o, last_pixel_o && !first_use_o && device_index_o == '0 && pen_number_o == '0)

  // Pixels of one word leave without gaps
  `PPIC_ASSERT_NXT(a_no_gap, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_pixel_o, out_valid_o)

  // Back-to-back repeat of a colour within a word is never a first use
  `PPIC_ASSERT_IMP(a_repeat, clk_i, rst_ni, (out_valid_o && !out_stall_i && !last_pixel_o) ##1 (out_valid_o && device_index_o == $past(device_index_o)), !first_use_o)

endmodule

bind planar_to_pen_index_converter ppic_checker u_ppic_checker (.*);

`default_nettype wire
